// File: hw/rtl/tmbs_pkg.sv
// ----------------------------------------------------------------------------
// tmbs_pkg
// Shared widths, mode codes and pipeline types of the temporal minimum
// background subtractor.
// ----------------------------------------------------------------------------
package tmbs_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int IDX_W      = $clog2(MAX_PIXELS);
	localparam int PIX_W      = 8;
	localparam int FP_W       = IDX_W + 1;

	localparam logic [FP_W-1:0] FRAME_PIXELS_RST = FP_W'(MAX_PIXELS);

	localparam logic [1:0] MODE_SEED  = 2'd0;
	localparam logic [1:0] MODE_LEARN = 2'd1;
	localparam logic [1:0] MODE_APPLY = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] pix;
		logic             eof;
		logic             err;
	} item_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [PIX_W-1:0] data;
	} wr_t;

endpackage

// File: hw/rtl/tmbs_ram.sv
// ----------------------------------------------------------------------------
// tmbs_ram
// Generic single-write, single-read RAM with registered, enabled read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module tmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/tmbs_back.sv
// ----------------------------------------------------------------------------
// tmbs_back
// Back end of the pipeline: background forwarding, minimum and seed update,
// saturating subtraction, ready flag and output register.
// ----------------------------------------------------------------------------
module tmbs_back
	import tmbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s2,
	input  item_t            item_s2,
	input  logic [PIX_W-1:0] rd_data,
	output wr_t              wr,
	output logic             adv,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_value,
	output logic             applied,
	output logic             index_error
);

	logic             fwd_en_q;
	logic [IDX_W-1:0] fwd_addr_q;
	logic [PIX_W-1:0] fwd_data_q;
	logic             ready_q;
	logic             ready_nxt;
	logic [PIX_W-1:0] bg;
	logic             ok;
	logic [PIX_W-1:0] val_nxt;
	logic             app_nxt;
	logic             err_nxt;

	assign adv = !out_valid || out_ready;
	assign ok  = vld_s2 && !item_s2.err;
	assign bg  = (fwd_en_q && fwd_addr_q == item_s2.idx) ? fwd_data_q : rd_data;

	always_comb begin
		wr.en     = 1'b0;
		wr.addr   = item_s2.idx;
		wr.data   = item_s2.pix;
		ready_nxt = ready_q;
		val_nxt   = '0;
		app_nxt   = 1'b0;
		err_nxt   = item_s2.err;
		unique case (item_s2.mode)
			MODE_SEED: begin
				wr.en     = adv && ok;
				ready_nxt = item_s2.eof;
			end
			MODE_LEARN: begin
				wr.en     = adv && ok;
				wr.data   = (item_s2.pix < bg) ? item_s2.pix : bg;
				ready_nxt = ready_q || item_s2.eof;
			end
			MODE_APPLY: begin
				if (!item_s2.err) begin
					if (ready_q) begin
						val_nxt = (item_s2.pix > bg) ? item_s2.pix - bg : '0;
						app_nxt = 1'b1;
					end else begin
						val_nxt = item_s2.pix;
					end
				end
			end
			default: begin
				err_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_en_q  <= 1'b0;
			ready_q   <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			fwd_en_q  <= wr.en;
			out_valid <= vld_s2;
			if (ok) begin
				ready_q <= ready_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q  <= wr.addr;
			fwd_data_q  <= wr.data;
			out_value   <= val_nxt;
			applied     <= app_nxt;
			index_error <= err_nxt;
		end
	end

endmodule

// File: hw/rtl/temporal_min_background_subtract_unit.sv
// ----------------------------------------------------------------------------
// temporal_min_background_subtract_unit
// Per-pixel temporal minimum background estimator and subtractor.
// ----------------------------------------------------------------------------
// One pixel byte is taken per clock while the output is not stalled, and
// each gives exactly one result; a stall on the output holds the whole
// pipeline. Stage 1 registers the item and checks the index against
// frame_pixels, stage 2 holds the background byte read from the 64K x 8
// single-port-write RAM (the most recent write is forwarded) and writes back
// the seed or minimum, stage 3 holds the result. Background entries are
// undefined until seeded, so there is no clearing pass after reset. Write
// frame_pixels only while the pipeline is empty.
module temporal_min_background_subtract_unit
	import tmbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [FP_W-1:0]  frame_pixels,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [IDX_W-1:0] pixel_index,
	input  logic [PIX_W-1:0] pixel_value,
	input  logic             end_of_frame,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_value,
	output logic             applied,
	output logic             index_error
);

	logic [FP_W-1:0]  frame_pixels_q;
	logic             adv;
	logic             vld_s1;
	logic             vld_s2;
	item_t            item_s1;
	item_t            item_s2;
	logic             err_in;
	logic [PIX_W-1:0] rd_data;
	wr_t              wr;

	assign cfg_ready = 1'b1;
	assign in_ready  = adv;
	assign err_in    = ({1'b0, pixel_index} >= frame_pixels_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_valid) begin
			frame_pixels_q <= frame_pixels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.mode <= mode;
			item_s1.idx  <= pixel_index;
			item_s1.pix  <= pixel_value;
			item_s1.eof  <= end_of_frame;
			item_s1.err  <= err_in;
			item_s2      <= item_s1;
		end
	end

	tmbs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_PIXELS)
	) u_bg_ram (
		.clk     (clk),
		.we      (wr.en),
		.wr_addr (wr.addr),
		.wr_data (wr.data),
		.re      (adv),
		.rd_addr (item_s1.idx),
		.rd_data (rd_data)
	);

	tmbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.vld_s2      (vld_s2),
		.item_s2     (item_s2),
		.rd_data     (rd_data),
		.wr          (wr),
		.adv         (adv),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.applied     (applied),
		.index_error (index_error)
	);

endmodule
